/* hdl/lcr_pkg.sv */
// Shared types, constants and helpers for the load cell reader.
// Used by every module under hdl; depends on nothing else.
package lcr_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int OUT_W           = 24;
  localparam int SCALE_W         = 52;
  localparam int WEIGHT_W        = 32;
  localparam int COUNT_W         = 8;
  localparam int DIFF_W          = OUT_W + 1;
  localparam int DIV_DEN_W       = WEIGHT_W;
  localparam int DIV_NUM_W       = DIFF_W + WEIGHT_W;
  localparam int SAT_IN_W        = 41;

  localparam logic [COUNT_W-1:0]        SAMPLE_COUNT_RESET = COUNT_W'(50);
  localparam logic [COUNT_W-1:0]        SAMPLE_COUNT_MAX   = COUNT_W'(255);
  localparam logic [WEIGHT_W-1:0]       WEIGHT_MIN_RAW     = WEIGHT_W'(65);
  localparam logic signed [SCALE_W-1:0] Q_ONE              = SCALE_W'(65536);

  localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'(8388607);
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_IN_W'(8388608);

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_AVERAGE = 2'd1,
    CMD_TARE    = 2'd2,
    CMD_CAL     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_SHIFT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CTL_TICK   = 2'd0,
    CTL_AVG    = 2'd1,
    CTL_FINISH = 2'd2,
    CTL_SCALE  = 2'd3
  } ctl_t;

  typedef struct packed {
    logic [1:0]          command;
    logic                dt_level;
    logic [WEIGHT_W-1:0] reference_weight;
  } item_t;

  typedef struct packed {
    logic                      sck_level;
    logic                      busy_res;
    logic                      sample_done;
    logic signed [OUT_W-1:0]   sample_value;
    logic                      op_done;
    logic signed [OUT_W-1:0]   average_value;
    logic signed [OUT_W-1:0]   tare_offset;
    logic signed [SCALE_W-1:0] scale_factor;
    logic                      scale_defaulted;
  } result_t;

  typedef struct packed {
    logic start;
    logic sck;
    logic done;
    logic busy;
  } smp_t;

  function automatic logic signed [OUT_W-1:0] sat24(input logic signed [SAT_IN_W-1:0] v);
    if (v > SAT_HI) begin
      return OUT_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      return OUT_W'(SAT_LO);
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

/* hdl/load_cell_reader_tare_calibrate.sv */
// Top level of the load cell reader: run control, accumulation, tare and calibration.
// Depends on lcr_pkg, lcr_sampler and lcr_div.
//
//   channel   signals                          payload
//   item      item_valid / item_ready          lcr_pkg::item_t, one serial half-clock tick
//   result    result_valid / result_ready      lcr_pkg::result_t, one per accepted tick
//   config    cfg_we / cfg_wdata               sample_count, 8 bits
//
// An ordinary tick's result sits in the output register and the next tick transfers as
// that result is taken. The tick that ends a run starts the bit-serial divider for the
// average; a calibration then divides again by the reference weight unless that weight
// is too small. Reset is synchronous, with no clearing pass. A stalled result holds the
// output register and blocks further ticks.
module load_cell_reader_tare_calibrate #(
  parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  lcr_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output lcr_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [lcr_pkg::COUNT_W-1:0]   cfg_wdata
);

  localparam int SW = SAMPLE_BITS + lcr_pkg::COUNT_W;

  lcr_pkg::ctl_t                          ctl, ctl_next;
  logic [1:0]                             op_kind;
  logic signed [SW-1:0]                   sum_acc;
  logic [lcr_pkg::COUNT_W-1:0]            samples_taken;
  logic [lcr_pkg::WEIGHT_W-1:0]           ref_weight;
  logic signed [lcr_pkg::OUT_W-1:0]       offset_reg;
  logic signed [lcr_pkg::SCALE_W-1:0]     scale_reg;
  logic [lcr_pkg::COUNT_W-1:0]            sample_count;
  logic                                   sum_neg;
  logic signed [lcr_pkg::OUT_W-1:0]       avg_reg;
  logic                                   pend_sck;
  logic signed [lcr_pkg::OUT_W-1:0]       pend_sval;

  lcr_pkg::smp_t                          smp;
  logic [SAMPLE_BITS-1:0]                 smp_sample;
  logic                                   tick;
  logic                                   run_end;
  logic [lcr_pkg::COUNT_W-1:0]            taken_inc;
  logic [lcr_pkg::COUNT_W-1:0]            n_eff;
  logic signed [SAMPLE_BITS-1:0]          sample_s;
  logic signed [SW-1:0]                   sum_next;
  logic [SW-1:0]                          sum_mag;
  logic signed [lcr_pkg::OUT_W-1:0]       sample_sat;
  logic signed [SAMPLE_BITS:0]            avg_pos;
  logic signed [SAMPLE_BITS:0]            avg_full;
  logic signed [lcr_pkg::OUT_W-1:0]       avg_sat;
  logic signed [lcr_pkg::DIFF_W-1:0]      diff;
  logic [lcr_pkg::DIFF_W-1:0]             diff_mag;
  logic signed [lcr_pkg::SCALE_W-1:0]     scale_pos;
  logic signed [lcr_pkg::SCALE_W-1:0]     scale_val;
  logic                                   tiny;
  logic                                   is_cal;
  logic                                   div_start;
  logic                                   div_done;
  logic [lcr_pkg::DIV_NUM_W-1:0]          div_num;
  logic [lcr_pkg::DIV_DEN_W-1:0]          div_den;
  logic [lcr_pkg::DIV_NUM_W-1:0]          div_quot;
  lcr_pkg::result_t                       tick_res;
  lcr_pkg::result_t                       fin_res;

  lcr_sampler #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_sampler (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .command  (item.command),
    .dt_level (item.dt_level),
    .run_end  (run_end),
    .ctl      (smp),
    .sample   (smp_sample)
  );

  lcr_div #(
    .NUM_W(lcr_pkg::DIV_NUM_W),
    .DEN_W(lcr_pkg::DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign tick = item_valid && item_ready;

  always_comb begin
    taken_inc  = (samples_taken == lcr_pkg::SAMPLE_COUNT_MAX) ? samples_taken
                                                              : samples_taken + 1'b1;
    n_eff      = (sample_count == '0) ? lcr_pkg::COUNT_W'(1) : sample_count;
    run_end    = smp.done && (taken_inc >= n_eff);
    sample_s   = $signed(smp_sample);
    sum_next   = sum_acc + SW'(sample_s);
    sum_mag    = sum_next[SW-1] ? -sum_next : sum_next;
    sample_sat = lcr_pkg::sat24(lcr_pkg::SAT_IN_W'(sample_s));
    avg_pos    = $signed({1'b0, div_quot[SAMPLE_BITS-1:0]});
    avg_full   = sum_neg ? -avg_pos : avg_pos;
    avg_sat    = lcr_pkg::sat24(lcr_pkg::SAT_IN_W'(avg_full));
    diff       = lcr_pkg::DIFF_W'(avg_reg) - lcr_pkg::DIFF_W'(offset_reg);
    diff_mag   = diff[lcr_pkg::DIFF_W-1] ? -diff : diff;
    scale_pos  = $signed(div_quot[lcr_pkg::SCALE_W-1:0]);
    scale_val  = diff[lcr_pkg::DIFF_W-1] ? -scale_pos : scale_pos;
    tiny       = (ref_weight <= lcr_pkg::WEIGHT_MIN_RAW);
    is_cal     = (op_kind == lcr_pkg::CMD_CAL);
  end

  always_comb begin
    if (ctl == lcr_pkg::CTL_FINISH) begin
      div_num = {diff_mag, {lcr_pkg::WEIGHT_W{1'b0}}};
      div_den = ref_weight;
    end else begin
      div_num = lcr_pkg::DIV_NUM_W'(sum_mag);
      div_den = lcr_pkg::DIV_DEN_W'(taken_inc);
    end
  end

  always_comb begin
    ctl_next = ctl;
    unique case (ctl)
      lcr_pkg::CTL_TICK: begin
        if (tick && run_end) begin
          ctl_next = lcr_pkg::CTL_AVG;
        end
      end
      lcr_pkg::CTL_AVG: begin
        if (div_done) begin
          ctl_next = lcr_pkg::CTL_FINISH;
        end
      end
      lcr_pkg::CTL_FINISH: begin
        ctl_next = (is_cal && !tiny) ? lcr_pkg::CTL_SCALE : lcr_pkg::CTL_TICK;
      end
      lcr_pkg::CTL_SCALE: begin
        if (div_done) begin
          ctl_next = lcr_pkg::CTL_TICK;
        end
      end
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    div_start  = 1'b0;
    unique case (ctl)
      lcr_pkg::CTL_TICK: begin
        item_ready = !result_valid || result_ready;
        div_start  = tick && run_end;
      end
      lcr_pkg::CTL_AVG: begin
      end
      lcr_pkg::CTL_FINISH: begin
        div_start = is_cal && !tiny;
      end
      lcr_pkg::CTL_SCALE: begin
      end
    endcase
  end

  always_comb begin
    tick_res.sck_level       = smp.sck;
    tick_res.busy_res        = smp.busy;
    tick_res.sample_done     = smp.done;
    tick_res.sample_value    = smp.done ? sample_sat : '0;
    tick_res.op_done         = 1'b0;
    tick_res.average_value   = '0;
    tick_res.tare_offset     = offset_reg;
    tick_res.scale_factor    = scale_reg;
    tick_res.scale_defaulted = 1'b0;

    fin_res.sck_level       = pend_sck;
    fin_res.busy_res        = 1'b0;
    fin_res.sample_done     = 1'b1;
    fin_res.sample_value    = pend_sval;
    fin_res.op_done         = 1'b1;
    fin_res.average_value   = avg_reg;
    fin_res.tare_offset     = (op_kind == lcr_pkg::CMD_TARE) ? avg_reg : offset_reg;
    fin_res.scale_factor    = (ctl == lcr_pkg::CTL_SCALE) ? scale_val :
                              (is_cal && tiny) ? lcr_pkg::Q_ONE : scale_reg;
    fin_res.scale_defaulted = is_cal && tiny;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl           <= lcr_pkg::CTL_TICK;
      result_valid  <= 1'b0;
      op_kind       <= lcr_pkg::CMD_TICK;
      sum_acc       <= '0;
      samples_taken <= '0;
      ref_weight    <= '0;
      offset_reg    <= '0;
      scale_reg     <= lcr_pkg::Q_ONE;
      sample_count  <= lcr_pkg::SAMPLE_COUNT_RESET;
    end else begin
      ctl <= ctl_next;
      if (cfg_we) begin
        sample_count <= cfg_wdata;
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (tick) begin
        if (smp.start) begin
          op_kind       <= item.command;
          sum_acc       <= '0;
          samples_taken <= '0;
          if (item.command == lcr_pkg::CMD_CAL) begin
            ref_weight <= item.reference_weight;
          end
        end
        if (smp.done) begin
          sum_acc       <= sum_next;
          samples_taken <= taken_inc;
        end
        if (!run_end) begin
          result_valid <= 1'b1;
        end
      end
      if (ctl == lcr_pkg::CTL_FINISH) begin
        if (op_kind == lcr_pkg::CMD_TARE) begin
          offset_reg <= avg_reg;
        end
        if (is_cal && tiny) begin
          scale_reg <= lcr_pkg::Q_ONE;
        end
        if (!(is_cal && !tiny)) begin
          result_valid <= 1'b1;
        end
      end
      if ((ctl == lcr_pkg::CTL_SCALE) && div_done) begin
        scale_reg    <= scale_val;
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      if (run_end) begin
        sum_neg   <= sum_next[SW-1];
        pend_sck  <= smp.sck;
        pend_sval <= sample_sat;
      end else begin
        result <= tick_res;
      end
    end
    if ((ctl == lcr_pkg::CTL_AVG) && div_done) begin
      avg_reg <= avg_sat;
    end
    if ((ctl == lcr_pkg::CTL_FINISH) && !(is_cal && !tiny)) begin
      result <= fin_res;
    end
    if ((ctl == lcr_pkg::CTL_SCALE) && div_done) begin
      result <= fin_res;
    end
  end

  a_div_done_in_run: assert property (@(posedge clk) disable iff (rst)
    div_done |-> ((ctl == lcr_pkg::CTL_AVG) || (ctl == lcr_pkg::CTL_SCALE)))
    else $error("divider finished outside a division step");

  a_run_end_divides: assert property (@(posedge clk) disable iff (rst)
    (tick && run_end) |=> ((ctl == lcr_pkg::CTL_AVG) && !result_valid))
    else $error("end of run did not start the average division");

  a_op_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.op_done) |-> (!result.busy_res && result.sample_done))
    else $error("finished run reported as busy or without a sample");

endmodule

/* hdl/lcr_sampler.sv */
// Serial clock sequencer and sample shift register of the load cell reader.
// Depends on lcr_pkg for the phase encoding and the control struct.
module lcr_sampler #(
  parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick,
  input  logic [1:0]             command,
  input  logic                   dt_level,
  input  logic                   run_end,
  output lcr_pkg::smp_t          ctl,
  output logic [SAMPLE_BITS-1:0] sample
);

  localparam int HW = $clog2(2 * SAMPLE_BITS + 2);
  localparam logic [HW-1:0] SHIFT_END = HW'(2 * SAMPLE_BITS);
  localparam logic [HW-1:0] LAST_HALF = HW'(2 * SAMPLE_BITS + 1);

  lcr_pkg::phase_t        phase, phase_next;
  logic [HW-1:0]          half, half_next;
  logic [SAMPLE_BITS-1:0] shift_reg, shift_reg_next;

  always_comb begin
    phase_next     = phase;
    half_next      = half;
    shift_reg_next = shift_reg;
    unique case (phase)
      lcr_pkg::PH_IDLE: begin
        if (command != lcr_pkg::CMD_TICK) begin
          phase_next     = lcr_pkg::PH_WAIT;
          half_next      = '0;
          shift_reg_next = '0;
        end
      end
      lcr_pkg::PH_WAIT: begin
        if (!dt_level) begin
          phase_next     = lcr_pkg::PH_SHIFT;
          half_next      = '0;
          shift_reg_next = '0;
        end
      end
      lcr_pkg::PH_SHIFT: begin
        if (!half[0]) begin
          if (half < SHIFT_END) begin
            shift_reg_next = {shift_reg[SAMPLE_BITS-2:0], 1'b0};
          end
        end else if (half < SHIFT_END) begin
          shift_reg_next = {shift_reg[SAMPLE_BITS-1:1], dt_level};
        end
        half_next = half + HW'(1);
        if (half == LAST_HALF) begin
          half_next  = '0;
          phase_next = run_end ? lcr_pkg::PH_IDLE : lcr_pkg::PH_WAIT;
        end
      end
      default: begin
        phase_next = lcr_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.start = (phase == lcr_pkg::PH_IDLE) && (command != lcr_pkg::CMD_TICK);
    ctl.sck   = (phase == lcr_pkg::PH_SHIFT) && !half[0];
    ctl.done  = (phase == lcr_pkg::PH_SHIFT) && (half == LAST_HALF);
    ctl.busy  = (phase_next != lcr_pkg::PH_IDLE);
  end

  assign sample = shift_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= lcr_pkg::PH_IDLE;
      half      <= '0;
      shift_reg <= '0;
    end else if (tick) begin
      phase     <= phase_next;
      half      <= half_next;
      shift_reg <= shift_reg_next;
    end
  end

endmodule

/* hdl/lcr_div.sv */
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on lcr_pkg for the default operand widths.
module lcr_div #(
  parameter int NUM_W = lcr_pkg::DIV_NUM_W,
  parameter int DEN_W = lcr_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_reg;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem, quot[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_reg};
    fits    = (rem_sh >= {1'b0, den_reg});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == CW'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(NUM_W);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot    <= num;
      rem     <= '0;
      den_reg <= den;
    end else if (busy) begin
      rem  <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule
